// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rph_pkg.sv
// ---------------------------------------------------------------------------
// rph_pkg
// Constants, stage types and the divider step of the ray panel hit test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rph_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_QB    = 35;
    localparam int UV_QB     = 17;

    localparam logic [34:0] OFF_CAP  = 35'h4_0000_0000;
    localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

    localparam logic [16:0] U_T1 = 17'd9831;
    localparam logic [16:0] U_T2 = 17'd19661;
    localparam logic [16:0] U_T3 = 17'd29492;

    localparam logic [2:0] RGN_NONE  = 3'd0;
    localparam logic [2:0] RGN_BACK  = 3'd1;
    localparam logic [2:0] RGN_PLAY  = 3'd2;
    localparam logic [2:0] RGN_FWD   = 3'd3;
    localparam logic [2:0] RGN_SCRUB = 3'd4;

    localparam logic [6:0]  SCRUB_MUL   = 7'd100;
    localparam logic [22:0] SCRUB_BASE  = 23'd2949120;
    localparam logic [22:0] SCRUB_DIV   = 23'd55;
    localparam logic [22:0] RECIP_55    = 23'd4880644;
    localparam int          RECIP_SHIFT = 28;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DIST   = 2'd2;
    localparam logic [1:0] CFG_VOFF   = 2'd3;

    typedef struct packed {
        logic               vld;
        logic               miss;
        logic [31:0]        dvs;
        logic               sx;
        logic               sy;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic [DIV_QB-1:0]  wx;
        logic [DIV_QB-1:0]  wy;
        logic [DIV_QB-1:0]  wt;
        logic [31:0]        rx;
        logic [31:0]        ry;
        logic [31:0]        rt;
        logic               fx;
        logic               fy;
        logic               ft;
    } dstg_t;

    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [30:0]      hdist;
        logic [UV_QB-1:0] wu;
        logic [UV_QB-1:0] wv;
        logic [31:0]      ru;
        logic [31:0]      rv;
    } uvstg_t;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [32:0] div_step(input logic [31:0] r, input logic b,
                                             input logic [31:0] d);
        logic [32:0] rr;
        rr = {r, b};
        if (rr >= {1'b0, d})
            return {1'b1, rr[31:0] - d};
        else
            return {1'b0, rr[31:0]};
    endfunction

endpackage

// File: rtl/ray_panel_hit_test_unit.sv
// ---------------------------------------------------------------------------
// ray_panel_hit_test_unit
// Ray against axis-aligned panel: hit flag, u, v, distance, region, scrub.
// ---------------------------------------------------------------------------
//  channel | dir | handshake          | content
//  s_*     | in  | tvalid/tready      | one ray, six Q16.16 words
//  m_*     | out | tvalid/tready      | hit in tuser, result fields in tdata
//  apb     | in  | psel/penable/pwrite| panel width, height, distance, offset
//
//  One ray per cycle while m_* is not stalled.
//  Two bit-serial divider pipelines (35 and 17 stages) do the divisions.
//  rst_n clears all valid bits and loads the panel reset values.
//  A stall at m_* holds every stage; s_tready drops in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ray_panel_hit_test_unit
    import rph_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,   // region, coord_u, coord_v, hit_distance, scrub_fraction
    output logic [0:0]   m_tuser,   // hit
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [30:0] w_reg;
    logic [30:0] h_reg;
    logic [31:0] pd_reg;
    logic [31:0] vo_reg;
    logic        pipe_en;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= 31'd65536;
            h_reg  <= 31'd65536;
            pd_reg <= 32'd131072;
            vo_reg <= 32'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                CFG_WIDTH:  w_reg  <= pwdata[30:0];
                CFG_HEIGHT: h_reg  <= pwdata[30:0];
                CFG_DIST:   pd_reg <= pwdata;
                CFG_VOFF:   vo_reg <= pwdata;
                default:    w_reg  <= w_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            CFG_WIDTH:  prdata = {1'b0, w_reg};
            CFG_HEIGHT: prdata = {1'b0, h_reg};
            CFG_DIST:   prdata = pd_reg;
            CFG_VOFF:   prdata = vo_reg;
            default:    prdata = '0;
        endcase
    end

    // stage 1: plane numerator and early miss
    logic               s1_vld_reg, s1_miss_reg, s1_sx_reg, s1_sy_reg;
    logic [32:0]        s1_anum_reg;
    logic [31:0]        s1_adz_reg, s1_dxm_reg, s1_dym_reg;
    logic signed [31:0] s1_ox_reg, s1_oy_reg;

    logic signed [31:0] in_oz, in_dx, in_dy, in_dz;
    logic signed [33:0] num;

    assign in_oz = s_tdata[95:64];
    assign in_dx = s_tdata[127:96];
    assign in_dy = s_tdata[159:128];
    assign in_dz = s_tdata[191:160];
    assign num   = -$signed({{2{pd_reg[31]}}, pd_reg}) - $signed({{2{in_oz[31]}}, in_oz});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (pipe_en)
        begin
            s1_vld_reg  <= s_tvalid;
            s1_miss_reg <= (in_dz == 32'sd0) || (w_reg == '0) || (h_reg == '0)
                           || (num == 34'sd0) || (num[33] != in_dz[31]);
            s1_anum_reg <= num[33] ? 33'(-num) : num[32:0];
            s1_adz_reg  <= in_dz[31] ? 32'(-in_dz) : in_dz;
            s1_dxm_reg  <= in_dx[31] ? 32'(-in_dx) : in_dx;
            s1_dym_reg  <= in_dy[31] ? 32'(-in_dy) : in_dy;
            s1_sx_reg   <= in_dx[31];
            s1_sy_reg   <= in_dy[31];
            s1_ox_reg   <= s_tdata[31:0];
            s1_oy_reg   <= s_tdata[63:32];
        end
    end

    // stage 2: offset products
    logic               s2_vld_reg, s2_miss_reg, s2_sx_reg, s2_sy_reg;
    logic [63:0]        s2_px_reg, s2_py_reg, s2_pt_reg;
    logic [31:0]        s2_adz_reg;
    logic signed [31:0] s2_ox_reg, s2_oy_reg;
    logic [64:0]        mul_x, mul_y;

    assign mul_x = 65'(s1_dxm_reg) * 65'(s1_anum_reg);
    assign mul_y = 65'(s1_dym_reg) * 65'(s1_anum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (pipe_en)
        begin
            s2_vld_reg  <= s1_vld_reg;
            s2_miss_reg <= s1_miss_reg;
            s2_px_reg   <= mul_x[63:0];
            s2_py_reg   <= mul_y[63:0];
            s2_pt_reg   <= 64'(s1_anum_reg) << FRAC_BITS;
            s2_adz_reg  <= s1_adz_reg;
            s2_sx_reg   <= s1_sx_reg;
            s2_sy_reg   <= s1_sy_reg;
            s2_ox_reg   <= s1_ox_reg;
            s2_oy_reg   <= s1_oy_reg;
        end
    end

    // divide by |dir_z|, three lanes, one quotient bit per stage
    dstg_t d_reg  [0:DIV_QB];
    dstg_t d_next [0:DIV_QB-1];
    dstg_t d0_next;

    always_comb
    begin
        d0_next.vld  = s2_vld_reg;
        d0_next.miss = s2_miss_reg;
        d0_next.dvs  = s2_adz_reg;
        d0_next.sx   = s2_sx_reg;
        d0_next.sy   = s2_sy_reg;
        d0_next.ox   = s2_ox_reg;
        d0_next.oy   = s2_oy_reg;
        d0_next.wx   = s2_px_reg[DIV_QB-1:0];
        d0_next.wy   = s2_py_reg[DIV_QB-1:0];
        d0_next.wt   = s2_pt_reg[DIV_QB-1:0];
        d0_next.rx   = 32'(s2_px_reg[63:DIV_QB]);
        d0_next.ry   = 32'(s2_py_reg[63:DIV_QB]);
        d0_next.rt   = 32'(s2_pt_reg[63:DIV_QB]);
        d0_next.fx   = 32'(s2_px_reg[63:DIV_QB]) >= s2_adz_reg;
        d0_next.fy   = 32'(s2_py_reg[63:DIV_QB]) >= s2_adz_reg;
        d0_next.ft   = 32'(s2_pt_reg[63:DIV_QB]) >= s2_adz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_reg[0] <= '0;
        else if (pipe_en)
            d_reg[0] <= d0_next;
    end

    for (genvar k = 0; k < DIV_QB; k++)
    begin : g_div
        logic [32:0] stx, sty, stt;

        assign stx = div_step(d_reg[k].rx, d_reg[k].wx[DIV_QB-1], d_reg[k].dvs);
        assign sty = div_step(d_reg[k].ry, d_reg[k].wy[DIV_QB-1], d_reg[k].dvs);
        assign stt = div_step(d_reg[k].rt, d_reg[k].wt[DIV_QB-1], d_reg[k].dvs);

        always_comb
        begin
            d_next[k]    = d_reg[k];
            d_next[k].rx = stx[31:0];
            d_next[k].ry = sty[31:0];
            d_next[k].rt = stt[31:0];
            d_next[k].wx = {d_reg[k].wx[DIV_QB-2:0], stx[32]};
            d_next[k].wy = {d_reg[k].wy[DIV_QB-2:0], sty[32]};
            d_next[k].wt = {d_reg[k].wt[DIV_QB-2:0], stt[32]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_reg[k+1] <= '0;
            else if (pipe_en)
                d_reg[k+1] <= d_next[k];
        end
    end

    // hit point and distance
    logic               e1_vld_reg, e1_miss_reg;
    logic signed [36:0] e1_px_reg;
    logic signed [37:0] e1_ly_reg;
    logic [30:0]        e1_dist_reg;
    logic [34:0]        off_x, off_y;

    assign off_x = (d_reg[DIV_QB].fx || d_reg[DIV_QB].wx > OFF_CAP) ? OFF_CAP
                                                                   : d_reg[DIV_QB].wx;
    assign off_y = (d_reg[DIV_QB].fy || d_reg[DIV_QB].wy > OFF_CAP) ? OFF_CAP
                                                                   : d_reg[DIV_QB].wy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e1_vld_reg <= 1'b0;
        else if (pipe_en)
        begin
            e1_vld_reg  <= d_reg[DIV_QB].vld;
            e1_miss_reg <= d_reg[DIV_QB].miss;
            e1_px_reg   <= d_reg[DIV_QB].sx
                           ? 37'(d_reg[DIV_QB].ox) - $signed({2'b00, off_x})
                           : 37'(d_reg[DIV_QB].ox) + $signed({2'b00, off_x});
            e1_ly_reg   <= (d_reg[DIV_QB].sy
                           ? 38'(d_reg[DIV_QB].oy) - $signed({3'b000, off_y})
                           : 38'(d_reg[DIV_QB].oy) + $signed({3'b000, off_y}))
                           - 38'($signed(vo_reg));
            e1_dist_reg <= (d_reg[DIV_QB].ft || d_reg[DIV_QB].wt > 35'(DIST_MAX))
                           ? DIST_MAX : d_reg[DIV_QB].wt[30:0];
        end
    end

    // rectangle test, then divide by 2w and 2h
    logic signed [39:0] pos_a, pos_b;
    logic               in_a, in_b;
    logic [31:0]        dv_u, dv_v;
    uvstg_t             uv_reg  [0:UV_QB];
    uvstg_t             uv_next [0:UV_QB-1];
    uvstg_t             uv0_next;

    assign dv_u  = {w_reg, 1'b0};
    assign dv_v  = {h_reg, 1'b0};
    assign pos_a = $signed({e1_px_reg, 1'b0}) + $signed({9'd0, w_reg});
    assign pos_b = $signed({e1_ly_reg, 1'b0}) + $signed({9'd0, h_reg});
    assign in_a  = !pos_a[39] && (pos_a[38:0] <= 39'(dv_u));
    assign in_b  = !pos_b[39] && (pos_b[38:0] <= 39'(dv_v));

    always_comb
    begin
        uv0_next.vld   = e1_vld_reg;
        uv0_next.hit   = !e1_miss_reg && in_a && in_b;
        uv0_next.hdist = e1_dist_reg;
        uv0_next.ru    = 32'(pos_a[31:1]);
        uv0_next.rv    = 32'(pos_b[31:1]);
        uv0_next.wu    = {pos_a[0], 16'd0};
        uv0_next.wv    = {pos_b[0], 16'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            uv_reg[0] <= '0;
        else if (pipe_en)
            uv_reg[0] <= uv0_next;
    end

    for (genvar k = 0; k < UV_QB; k++)
    begin : g_uv
        logic [32:0] stu, stv;

        assign stu = div_step(uv_reg[k].ru, uv_reg[k].wu[UV_QB-1], dv_u);
        assign stv = div_step(uv_reg[k].rv, uv_reg[k].wv[UV_QB-1], dv_v);

        always_comb
        begin
            uv_next[k]    = uv_reg[k];
            uv_next[k].ru = stu[31:0];
            uv_next[k].rv = stv[31:0];
            uv_next[k].wu = {uv_reg[k].wu[UV_QB-2:0], stu[32]};
            uv_next[k].wv = {uv_reg[k].wv[UV_QB-2:0], stv[32]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                uv_reg[k+1] <= '0;
            else if (pipe_en)
                uv_reg[k+1] <= uv_next[k];
        end
    end

    // region and scrub numerator
    logic        f1_vld_reg, f1_hit_reg;
    logic [2:0]  f1_rgn_reg;
    logic [16:0] f1_u_reg, f1_v_reg;
    logic [30:0] f1_dist_reg;
    logic [21:0] f1_n_reg;
    logic [2:0]  rgn;
    logic [16:0] uq;
    logic [22:0] n_full;

    assign uq     = uv_reg[UV_QB].wu;
    assign n_full = 23'(uq) * 23'(SCRUB_MUL) - SCRUB_BASE;

    always_comb
    begin
        if (uq < U_T1)
            rgn = RGN_BACK;
        else if (uq < U_T2)
            rgn = RGN_PLAY;
        else if (uq < U_T3)
            rgn = RGN_FWD;
        else
            rgn = RGN_SCRUB;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_vld_reg <= 1'b0;
        else if (pipe_en)
        begin
            f1_vld_reg  <= uv_reg[UV_QB].vld;
            f1_hit_reg  <= uv_reg[UV_QB].hit;
            f1_rgn_reg  <= rgn;
            f1_u_reg    <= uq;
            f1_v_reg    <= uv_reg[UV_QB].wv;
            f1_dist_reg <= uv_reg[UV_QB].hdist;
            f1_n_reg    <= n_full[21:0];
        end
    end

    // divide by 55: reciprocal estimate
    logic        f2_vld_reg, f2_hit_reg;
    logic [2:0]  f2_rgn_reg;
    logic [16:0] f2_u_reg, f2_v_reg, f2_q_reg;
    logic [30:0] f2_dist_reg;
    logic [21:0] f2_n_reg;
    logic [44:0] recip_prod;

    assign recip_prod = 45'(f1_n_reg) * 45'(RECIP_55);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_vld_reg <= 1'b0;
        else if (pipe_en)
        begin
            f2_vld_reg  <= f1_vld_reg;
            f2_hit_reg  <= f1_hit_reg;
            f2_rgn_reg  <= f1_rgn_reg;
            f2_u_reg    <= f1_u_reg;
            f2_v_reg    <= f1_v_reg;
            f2_dist_reg <= f1_dist_reg;
            f2_n_reg    <= f1_n_reg;
            f2_q_reg    <= recip_prod[44:RECIP_SHIFT];
        end
    end

    // correct the estimate and drive the output word
    logic        out_vld_reg, out_hit_reg;
    logic [2:0]  out_rgn_reg;
    logic [16:0] out_u_reg, out_v_reg, out_frac_reg;
    logic [30:0] out_dist_reg;
    logic [22:0] rem55;
    logic [16:0] frac_q;

    assign rem55  = {1'b0, f2_n_reg} - 23'(f2_q_reg) * SCRUB_DIV;
    assign frac_q = (rem55 >= SCRUB_DIV) ? f2_q_reg + 17'd1 : f2_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (pipe_en)
        begin
            out_vld_reg  <= f2_vld_reg;
            out_hit_reg  <= f2_hit_reg;
            out_rgn_reg  <= f2_hit_reg ? f2_rgn_reg : RGN_NONE;
            out_u_reg    <= f2_hit_reg ? f2_u_reg : '0;
            out_v_reg    <= f2_hit_reg ? f2_v_reg : '0;
            out_dist_reg <= f2_hit_reg ? f2_dist_reg : '0;
            out_frac_reg <= (f2_hit_reg && f2_rgn_reg == RGN_SCRUB) ? frac_q : '0;
        end
    end

    assign pipe_en  = !out_vld_reg || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {3'b000, out_frac_reg, out_dist_reg, out_v_reg, out_u_reg, out_rgn_reg};

    `CHK_IMPL(a_miss_clear, out_vld_reg && !out_hit_reg,
        out_rgn_reg == RGN_NONE && out_u_reg == '0 && out_v_reg == '0
        && out_dist_reg == '0 && out_frac_reg == '0, "miss word not cleared")
    `CHK_IMPL(a_hit_fields, out_vld_reg && out_hit_reg,
        out_rgn_reg != RGN_NONE && out_u_reg <= 17'd65536, "hit word out of range")
    `CHK_IMPL(a_scrub_only, out_vld_reg && out_rgn_reg != RGN_SCRUB,
        out_frac_reg == '0, "scrub fraction outside scrubber")
    `CHK_NEXT(a_stall_hold, !pipe_en,
        $stable(s1_vld_reg) && $stable(e1_vld_reg) && $stable(out_vld_reg),
        "pipeline moved during stall")

endmodule

// File: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Ray against panel hit test: directed and random rays under several panel
// settings, bursty input, random output stalls and one long stall. Results
// are checked field by field against an in-bench hit predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import rph_pkg::*;

    typedef struct packed {
        logic signed [31:0] dz;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
        logic signed [31:0] oz;
        logic signed [31:0] oy;
        logic signed [31:0] ox;
    } ray_t;

    typedef struct {
        logic        hit;
        logic [2:0]  region;
        logic [16:0] coord_u;
        logic [16:0] coord_v;
        logic [30:0] hit_dist;
        logic [16:0] scrub;
    } hit_result_t;

    localparam longint DZ_MIN = 1;
    localparam int     LONG_HOLD_AT = 400;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;   // region, coord_u, coord_v, hit_distance, scrub_fraction
    logic [0:0]   m_tuser;   // hit
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    logic [30:0]        panel_w;
    logic [30:0]        panel_h;
    logic signed [31:0] panel_dist;
    logic signed [31:0] panel_voff;

    ray_t        ray_queue[$];
    hit_result_t expected_hits[$];
    int          mismatches;
    int          accepted_rays;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    logic        long_hold_done;
    int          stall_phase;

    ray_panel_hit_test_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] magnitude(input longint val);
        return (val < 0) ? 64'(-val) : 64'(val);
    endfunction

    function automatic longint hit_coord(input longint org, input longint dir,
                                         input logic [63:0] anum, input logic [63:0] adz);
        logic [63:0] off;
        off = (magnitude(dir) * anum) / adz;
        if (off > 64'(OFF_CAP))
            off = 64'(OFF_CAP);
        return (dir < 0) ? org - longint'(off) : org + longint'(off);
    endfunction

    function automatic hit_result_t predict_hit(input ray_t r);
        hit_result_t res;
        longint      w;
        longint      h;
        longint      num;
        longint      px;
        longint      ly;
        logic [63:0] adz;
        logic [63:0] anum;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] span;
        res = '{1'b0, RGN_NONE, 17'd0, 17'd0, 31'd0, 17'd0};
        w = longint'(panel_w);
        h = longint'(panel_h);
        adz = magnitude(longint'(r.dz));
        if (adz < DZ_MIN || w == 0 || h == 0)
            return res;
        num = -longint'(panel_dist) - longint'(r.oz);
        if (num == 0 || ((num > 0) != (r.dz > 0)))
            return res;
        anum = magnitude(num);
        px = hit_coord(longint'(r.ox), longint'(r.dx), anum, adz);
        ly = hit_coord(longint'(r.oy), longint'(r.dy), anum, adz) - longint'(panel_voff);
        if (2 * px < -w || 2 * px > w || 2 * ly < -h || 2 * ly > h)
            return res;
        t = (anum << FRAC_BITS) / adz;
        if (t > 64'(DIST_MAX))
            t = 64'(DIST_MAX);
        span = 64'(2 * px + w);
        u = (span << 16) / 64'(2 * w);
        span = 64'(2 * ly + h);
        v = (span << 16) / 64'(2 * h);
        res.hit = 1'b1;
        res.coord_u = u[16:0];
        res.coord_v = v[16:0];
        res.hit_dist = t[30:0];
        if (u < 64'(U_T1))
            res.region = RGN_BACK;
        else if (u < 64'(U_T2))
            res.region = RGN_PLAY;
        else if (u < 64'(U_T3))
            res.region = RGN_FWD;
        else
        begin
            res.region = RGN_SCRUB;
            t = (64'(SCRUB_MUL) * u - 64'(SCRUB_BASE)) / 64'(SCRUB_DIV);
            res.scrub = t[16:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // sender: bursts with gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left <= 0;
            gap_left <= 0;
            accepted_rays <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_hits.push_back(predict_hit(ray_t'(s_tdata)));
                accepted_rays <= accepted_rays + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (ray_queue.size() > 0)
                begin
                    s_tdata <= ray_queue.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && accepted_rays >= LONG_HOLD_AT)
        begin
            hold_left <= 300;
            long_hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // receiver: stall pattern, with quiet stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 97;
            if (hold_left > 0)
                m_tready <= 1'b0;
            else if (stall_phase < 30)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        hit_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_hits.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = expected_hits.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", m_tuser[0], want.hit);
                if (m_tdata[2:0] !== want.region)
                    report_mismatch("region", m_tdata[2:0], want.region);
                if (m_tdata[19:3] !== want.coord_u)
                    report_mismatch("coord_u", m_tdata[19:3], want.coord_u);
                if (m_tdata[36:20] !== want.coord_v)
                    report_mismatch("coord_v", m_tdata[36:20], want.coord_v);
                if (m_tdata[67:37] !== want.hit_dist)
                    report_mismatch("hit_distance", m_tdata[67:37], want.hit_dist);
                if (m_tdata[84:68] !== want.scrub)
                    report_mismatch("scrub_fraction", m_tdata[84:68], want.scrub);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            CFG_WIDTH:  panel_w = val[30:0];
            CFG_HEIGHT: panel_h = val[30:0];
            CFG_DIST:   panel_dist = val;
            default:    panel_voff = val;
        endcase
    endtask

    task automatic set_panel(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] d, input logic [31:0] vo);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_DIST, d);
        write_reg(CFG_VOFF, vo);
    endtask

    task automatic add_ray(input int ox, input int oy, input int oz,
                           input int dx, input int dy, input int dz);
        ray_queue.push_back('{dz, dy, dx, oz, oy, ox});
    endtask

    task automatic wait_idle();
        wait (ray_queue.size() == 0 && !s_tvalid && expected_hits.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    // rays aimed roughly at the panel, with some pure noise
    task automatic add_random_rays(input int count);
        int     dz;
        longint half_w;
        longint half_h;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 3)
                add_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            else
            begin
                half_w = longint'(panel_w) / 2 + 1;
                half_h = longint'(panel_h) / 2 + 1;
                if (half_w > 64'h3FFF_FFFF)
                    half_w = 64'h3FFF_FFFF;
                if (half_h > 64'h3FFF_FFFF)
                    half_h = 64'h3FFF_FFFF;
                dz = $urandom_range(1, 1 << 17);
                if (panel_dist > 0 || (panel_dist == 0 && $urandom_range(0, 1) == 0))
                    dz = -dz;
                add_ray(int'(longint'($urandom_range(0, 2 * half_w)) - half_w),
                        int'(longint'(panel_voff) + longint'($urandom_range(0, 2 * half_h))
                             - half_h),
                        int'($urandom_range(0, 8191)) - 4096,
                        int'($urandom_range(0, 1 << 13)) - (1 << 12),
                        int'($urandom_range(0, 1 << 13)) - (1 << 12),
                        dz);
            end
        end
    endtask

    initial
    begin
        mismatches = 0;
        panel_w = 31'd65536;
        panel_h = 31'd65536;
        panel_dist = 32'sd131072;
        panel_voff = 32'sd0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: plane at z = -2, unit panel
        add_ray(0, 0, 0, 0, 0, 0);
        add_ray(0, 0, 0, 0, 0, 65536);
        add_ray(0, 0, -131072, 0, 0, -65536);
        add_ray(0, 0, -131071, 0, 0, -65536);
        add_ray(0, 0, 0, 0, 0, -65536);
        add_ray(0, 0, 0, -16384, -16384, -65536);
        add_ray(0, 0, 0, 16384, 16384, -65536);
        add_ray(0, 0, 0, 16385, 0, -65536);
        add_ray(0, 0, 0, 0, -16385, -65536);
        add_ray(0, 0, 0, -11469, 0, -65536);
        add_ray(1, 0, 0, -11469, 0, -65536);
        add_ray(0, 0, 0, -6554, 0, -65536);
        add_ray(1, 0, 0, -6554, 0, -65536);
        add_ray(0, 0, 0, -1638, 0, -65536);
        add_ray(0, 0, 0, -1638, 1, -65536);
        add_ray(0, 0, 0, 0, 0, -1);
        add_ray(0, 0, 2147483647, 0, 0, -1);
        add_ray(-2147483648, -2147483648, -2147483648, -2147483648, -2147483648, 1);
        add_ray(2147483647, 2147483647, 2147483647, 2147483647, 2147483647, -2147483648);
        add_ray(-32768, 32768, 0, 0, 0, -1000);
        add_ray(0, 0, 0, 0, 0, -2147483648);
        wait_idle();

        set_panel(32'd65536, 32'd65536, 32'd131072, 32'd0);
        add_random_rays(170);
        wait_idle();
        set_panel(32'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        add_random_rays(170);
        wait_idle();
        set_panel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_random_rays(170);
        wait_idle();
        set_panel(32'd196608, 32'd131072, 32'd327680, 32'd32768);
        add_random_rays(170);
        wait_idle();
        set_panel(32'd200000, 32'd70000, -32'sd262144, -32'sd65536);
        add_random_rays(170);
        wait_idle();

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
